### rtl/u8d_pkg.sv
package u8d_pkg;

    // Field widths
    localparam int CP_W      = 21;
    localparam int BYTE_W    = 8;
    localparam int ERR_CNT_W = 3;

    // Descriptor queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Replacement code after reset: '?'
    localparam logic [CP_W-1:0] REPL_RESET = CP_W'(63);

    // Sequence length codes
    typedef logic [2:0] seq_len_t;
    localparam seq_len_t SEQ_NONE  = 3'd0;
    localparam seq_len_t SEQ_TWO   = 3'd2;
    localparam seq_len_t SEQ_THREE = 3'd3;
    localparam seq_len_t SEQ_FOUR  = 3'd4;

    // Input channel payload
    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_string;
    } in_item_t;

    // Result channel payload
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_error;
        logic            last_of_run;
    } out_item_t;

    // One accepted byte's results: err_cnt replacements, then an optional value
    typedef struct packed {
        logic [ERR_CNT_W-1:0] err_cnt;
        logic                 has_val;
        logic [CP_W-1:0]      value;
    } desc_t;

    // Overlong, out of range or surrogate
    function automatic logic cp_invalid(input logic [CP_W-1:0] cp, input seq_len_t len);
        logic overlong;
        overlong = ((len == SEQ_TWO)   && (cp < CP_W'(32'h80)))   ||
                   ((len == SEQ_THREE) && (cp < CP_W'(32'h800)))  ||
                   ((len == SEQ_FOUR)  && (cp < CP_W'(32'h10000)));
        return overlong || (cp > CP_W'(32'h10FFFF)) ||
               ((cp >= CP_W'(32'hD800)) && (cp <= CP_W'(32'hDFFF)));
    endfunction

endpackage

### rtl/u8d_front.sv
module u8d_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  u8d_pkg::in_item_t  s_item,
    output logic               push,
    output u8d_pkg::desc_t     push_desc
);

    logic [u8d_pkg::CP_W-1:0]      pv_reg, pv_next;
    u8d_pkg::seq_len_t             len_reg, len_next;
    logic [1:0]                    br_reg, br_next;

    logic                          pending;
    logic                          is_cont;
    logic [u8d_pkg::CP_W-1:0]      cont_pv;
    logic [2:0]                    cont_br;
    logic [u8d_pkg::ERR_CNT_W-1:0] flush_cnt;
    logic [u8d_pkg::BYTE_W-1:0]    b;

    assign b       = s_item.in_byte;
    assign pending = (len_reg != u8d_pkg::SEQ_NONE);
    assign is_cont = (b[7:6] == 2'b10);
    assign cont_pv = {pv_reg[u8d_pkg::CP_W-7:0], b[5:0]};
    assign cont_br = {1'b0, br_reg} + 3'd1;
    assign flush_cnt = pending ? u8d_pkg::ERR_CNT_W'(br_reg) : '0;

    // Classify the byte against the pending sequence
    always_comb begin
        pv_next   = pv_reg;
        len_next  = len_reg;
        br_next   = br_reg;
        push_desc = '0;
        if (b == '0) begin
            // terminator: flush buffered bytes, nothing for itself
            push_desc.err_cnt = flush_cnt;
            pv_next  = '0;
            len_next = u8d_pkg::SEQ_NONE;
            br_next  = '0;
        end else if (pending && is_cont) begin
            if (cont_br >= len_reg) begin
                // sequence complete
                if (u8d_pkg::cp_invalid(cont_pv, len_reg)) begin
                    push_desc.err_cnt = len_reg;
                end else begin
                    push_desc.has_val = 1'b1;
                    push_desc.value   = cont_pv;
                end
                pv_next  = '0;
                len_next = u8d_pkg::SEQ_NONE;
                br_next  = '0;
            end else if (s_item.end_of_string) begin
                push_desc.err_cnt = cont_br;
                pv_next  = '0;
                len_next = u8d_pkg::SEQ_NONE;
                br_next  = '0;
            end else begin
                pv_next = cont_pv;
                br_next = cont_br[1:0];
            end
        end else begin
            // breaking byte or idle: flush, then decode afresh
            push_desc.err_cnt = flush_cnt;
            pv_next  = '0;
            len_next = u8d_pkg::SEQ_NONE;
            br_next  = '0;
            if (!b[7]) begin
                push_desc.has_val = 1'b1;
                push_desc.value   = u8d_pkg::CP_W'(b);
            end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
                if (s_item.end_of_string) begin
                    // lone lead at end of string
                    push_desc.err_cnt = flush_cnt + u8d_pkg::ERR_CNT_W'(1);
                end else begin
                    br_next = 2'd1;
                    if (b[7:5] == 3'b110) begin
                        pv_next  = u8d_pkg::CP_W'(b[4:0]);
                        len_next = u8d_pkg::SEQ_TWO;
                    end else if (b[7:4] == 4'b1110) begin
                        pv_next  = u8d_pkg::CP_W'(b[3:0]);
                        len_next = u8d_pkg::SEQ_THREE;
                    end else begin
                        pv_next  = u8d_pkg::CP_W'(b[2:0]);
                        len_next = u8d_pkg::SEQ_FOUR;
                    end
                end
            end else begin
                // stray continuation or 11111xxx
                push_desc.err_cnt = flush_cnt + u8d_pkg::ERR_CNT_W'(1);
            end
        end
    end

    assign push = s_valid && s_ready &&
                  ((push_desc.err_cnt != '0) || push_desc.has_val);

    // Sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg  <= '0;
            len_reg <= u8d_pkg::SEQ_NONE;
            br_reg  <= '0;
        end else if (s_valid && s_ready) begin
            pv_reg  <= pv_next;
            len_reg <= len_next;
            br_reg  <= br_next;
        end
    end

endmodule

### rtl/u8d_queue.sv
module u8d_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  u8d_pkg::desc_t  push_desc,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output u8d_pkg::desc_t  head_desc
);

    u8d_pkg::desc_t                  mem [u8d_pkg::QDEPTH];
    logic [u8d_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [u8d_pkg::QCNT_W-1:0]      count_reg;
    logic                            do_pop;

    assign full       = (count_reg == u8d_pkg::QCNT_W'(u8d_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + u8d_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + u8d_pkg::QPTR_W'(1);
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + u8d_pkg::QCNT_W'(1);
            end else if (!push && do_pop) begin
                count_reg <= count_reg - u8d_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

### rtl/u8d_back.sv
module u8d_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [u8d_pkg::CP_W-1:0] repl_code,
    input  logic                     head_valid,
    input  u8d_pkg::desc_t           head_desc,
    output logic                     pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output u8d_pkg::out_item_t       m_item
);

    logic                          m_valid_reg;
    u8d_pkg::out_item_t            m_item_reg, m_item_next;
    logic [1:0]                    idx_reg;
    logic                          load;
    logic                          is_rep;
    logic                          is_last;
    logic [u8d_pkg::ERR_CNT_W-1:0] total;

    assign load    = !m_valid_reg || m_ready;
    assign total   = head_desc.err_cnt + u8d_pkg::ERR_CNT_W'(head_desc.has_val);
    assign is_rep  = (u8d_pkg::ERR_CNT_W'(idx_reg) < head_desc.err_cnt);
    assign is_last = ((u8d_pkg::ERR_CNT_W'(idx_reg) + u8d_pkg::ERR_CNT_W'(1)) == total);
    assign pop     = load && head_valid && is_last;

    // Pick result idx of the head transaction
    always_comb begin
        m_item_next.code_point  = is_rep ? repl_code : head_desc.value;
        m_item_next.is_error    = is_rep;
        m_item_next.last_of_run = is_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else if (load) begin
            m_valid_reg <= head_valid;
            if (pop) begin
                idx_reg <= '0;
            end else if (head_valid) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### rtl/utf8_codepoint_decoder_core.sv
// An accepted byte's first result is registered in the descriptor queue and then in
// the output register.
// Throughput: one byte per cycle while each byte gives at most one result and the
// output is not stalled; a byte giving k results holds the output register for its k
// results in turn, and a 4-entry descriptor queue lets the input keep running meanwhile.
// Reset: synchronous active-low aresetn clears the pending sequence, the queue and
// the output valid, and sets the replacement code to '?' (63).
module utf8_codepoint_decoder_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  u8d_pkg::in_item_t        s_item,
    output logic                     m_valid,
    input  logic                     m_ready,
    output u8d_pkg::out_item_t       m_item,
    input  logic                     cfg_wr_en,
    input  logic [u8d_pkg::CP_W-1:0] cfg_wr_data
);

    logic [u8d_pkg::CP_W-1:0] repl_code_reg;
    logic                     push;
    u8d_pkg::desc_t           push_desc;
    logic                     full;
    logic                     pop;
    logic                     head_valid;
    u8d_pkg::desc_t           head_desc;

    assign s_ready = !full;

    // Replacement code register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repl_code_reg <= u8d_pkg::REPL_RESET;
        end else if (cfg_wr_en) begin
            repl_code_reg <= cfg_wr_data;
        end
    end

    u8d_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .push      (push),
        .push_desc (push_desc)
    );

    u8d_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_desc  (push_desc),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    u8d_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .repl_code  (repl_code_reg),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

    // Every queued descriptor carries at least one result
    a_desc_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> ((head_desc.err_cnt != '0) || head_desc.has_val))
        else $error("empty descriptor in queue");

    // A decoded value is always the final result of its byte
    a_value_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.is_error) |-> m_item.last_of_run)
        else $error("decoded value not marked last");

    // Nothing is presented right after reset
    a_reset_idle: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_valid)
        else $error("result valid right after reset");

endmodule
